/* rtl/core/tpmc_pkg.sv */
// Shared types, constants and helpers of the threshold point-merge clustering core.
package tpmc_pkg;

	localparam int COORD_W        = 24;
	localparam int THR_W          = 16;
	localparam int MAX_POINTS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(300);

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	typedef enum logic [1:0] {
		COORD_X = 2'd0,
		COORD_Y = 2'd1,
		COORD_Z = 2'd2
	} coord_t;

	typedef struct packed {
		logic   load_wr;
		logic   thr_sq;
		logic   r_clr;
		logic   r_inc;
		logic   j_clr;
		logic   j_inc;
		logic   sel_ref;
		logic   ref_ld;
		logic   mask_clr;
		logic   sq_en;
		coord_t sq_coord;
		logic   acc_ld;
		logic   acc_add;
		logic   near_chk;
		logic   merge_init;
		logic   acc_pt;
		logic   div_start;
		logic   div_step;
		logic   div_wr;
		logic   out_ld;
		logic   cnt_clr;
	} dp_cmd_t;

	typedef struct packed {
		logic r_end;
		logic j_end;
		logic j_last;
		logic rd_valid;
		logic mask_zero;
		logic div_done;
	} dp_stat_t;

	function automatic logic pt_valid(point_t p);
		return (p.x != '0) && (p.y != '0) && (p.z != '0);
	endfunction

endpackage

/* rtl/core/tpmc_ctrl.sv */
// Controller state machine: sequences load, neighbor search, merge, divide and emit.
module tpmc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_last,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  tpmc_pkg::dp_stat_t stat,
	output tpmc_pkg::dp_cmd_t  cmd
);
	import tpmc_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE      = 16'h0001,
		S_THR       = 16'h0002,
		S_REF_RD    = 16'h0004,
		S_REF_LD    = 16'h0008,
		S_J_RD      = 16'h0010,
		S_J_X       = 16'h0020,
		S_J_Y       = 16'h0040,
		S_J_Z       = 16'h0080,
		S_J_CMP     = 16'h0100,
		S_M_RD      = 16'h0200,
		S_M_ACC     = 16'h0400,
		S_DIV       = 16'h0800,
		S_DIV_WR    = 16'h1000,
		S_EMIT_RD   = 16'h2000,
		S_EMIT_LD   = 16'h4000,
		S_EMIT_WAIT = 16'h8000
	} state_t;

	state_t state_q, state_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_EMIT_WAIT);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.sq_coord = COORD_X;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_wr = 1'b1;
					if (in_last) state_d = S_THR;
				end
			end
			S_THR: begin
				cmd.thr_sq = 1'b1;
				cmd.r_clr  = 1'b1;
				state_d    = S_REF_RD;
			end
			S_REF_RD: begin
				if (stat.r_end) begin
					cmd.j_clr = 1'b1;
					state_d   = S_EMIT_RD;
				end else begin
					cmd.sel_ref = 1'b1;
					state_d     = S_REF_LD;
				end
			end
			S_REF_LD: begin
				cmd.ref_ld = 1'b1;
				if (!stat.rd_valid) begin
					cmd.r_inc = 1'b1;
					state_d   = S_REF_RD;
				end else begin
					cmd.j_clr    = 1'b1;
					cmd.mask_clr = 1'b1;
					state_d      = S_J_RD;
				end
			end
			S_J_RD: begin
				if (stat.j_end) begin
					if (stat.mask_zero) begin
						cmd.r_inc = 1'b1;
						state_d   = S_REF_RD;
					end else begin
						cmd.merge_init = 1'b1;
						state_d        = S_M_RD;
					end
				end else begin
					state_d = S_J_X;
				end
			end
			S_J_X: begin
				cmd.sq_en    = 1'b1;
				cmd.sq_coord = COORD_X;
				state_d      = S_J_Y;
			end
			S_J_Y: begin
				cmd.sq_en    = 1'b1;
				cmd.sq_coord = COORD_Y;
				cmd.acc_ld   = 1'b1;
				state_d      = S_J_Z;
			end
			S_J_Z: begin
				cmd.sq_en    = 1'b1;
				cmd.sq_coord = COORD_Z;
				cmd.acc_add  = 1'b1;
				state_d      = S_J_CMP;
			end
			S_J_CMP: begin
				cmd.near_chk = 1'b1;
				cmd.j_inc    = 1'b1;
				state_d      = S_J_RD;
			end
			S_M_RD: begin
				if (stat.j_end) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					state_d = S_M_ACC;
				end
			end
			S_M_ACC: begin
				cmd.acc_pt = 1'b1;
				cmd.j_inc  = 1'b1;
				state_d    = S_M_RD;
			end
			S_DIV: begin
				if (stat.div_done) state_d = S_DIV_WR;
				else cmd.div_step = 1'b1;
			end
			S_DIV_WR: begin
				cmd.div_wr = 1'b1;
				cmd.r_clr  = 1'b1;
				state_d    = S_REF_RD;
			end
			S_EMIT_RD: begin
				state_d = S_EMIT_LD;
			end
			S_EMIT_LD: begin
				cmd.out_ld = 1'b1;
				state_d    = S_EMIT_WAIT;
			end
			S_EMIT_WAIT: begin
				if (out_ready) begin
					cmd.j_inc = 1'b1;
					if (stat.j_last) begin
						cmd.cnt_clr = 1'b1;
						state_d     = S_IDLE;
					end else begin
						state_d = S_EMIT_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

/* rtl/core/tpmc_dp.sv */
// Datapath: point banks, counters, distance unit, mean accumulators and divider.
module tpmc_dp #(
	parameter int MAX_POINTS = tpmc_pkg::MAX_POINTS_DEF,
	parameter int FRAC_BITS  = tpmc_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  tpmc_pkg::dp_cmd_t                      cmd,
	output tpmc_pkg::dp_stat_t                     stat,
	input  logic                                   cfg_valid,
	input  logic [tpmc_pkg::THR_W-1:0]             cfg_data,
	input  logic signed [tpmc_pkg::COORD_W-1:0]    in_x,
	input  logic signed [tpmc_pkg::COORD_W-1:0]    in_y,
	input  logic signed [tpmc_pkg::COORD_W-1:0]    in_z,
	output logic signed [tpmc_pkg::COORD_W-1:0]    out_x,
	output logic signed [tpmc_pkg::COORD_W-1:0]    out_y,
	output logic signed [tpmc_pkg::COORD_W-1:0]    out_z,
	output logic                                   out_last
);
	import tpmc_pkg::*;

	localparam int IDX_W  = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int DIF_W  = COORD_W + 1;
	localparam int SQ_W   = 2 * DIF_W;
	localparam int D2_W   = SQ_W + 2;
	localparam int TW     = THR_W + FRAC_BITS;
	localparam int TSQ_W  = 2 * TW;
	localparam int CMP_W  = (TSQ_W > D2_W) ? TSQ_W : D2_W;
	localparam int SUM_W  = COORD_W + CNT_W;
	localparam int REM_W  = CNT_W + 1;
	localparam int DCNT_W = $clog2(SUM_W + 1);

	// two banks: merge reads the current one and compacts into the other
	point_t mem0 [MAX_POINTS];
	point_t mem1 [MAX_POINTS];
	logic   bank_q;
	point_t rdata_q;

	logic [THR_W-1:0]      thr_q;
	logic [TSQ_W-1:0]      thr_sq_q;
	logic [CNT_W-1:0]      cnt_q, r_q, j_q, k_q, n_q;
	logic [MAX_POINTS-1:0] mask_q;
	point_t                ref_q;
	logic [SQ_W-1:0]       sq_q;
	logic [D2_W-1:0]       acc_q;

	logic signed [SUM_W-1:0] sum_q [3];
	logic [SUM_W-1:0]        quo_q [3];
	logic [REM_W-1:0]        rem_q [3];
	logic                    neg_q [3];
	logic [DCNT_W-1:0]       dcnt_q;

	logic [IDX_W-1:0]         rd_addr;
	logic                     wr_en, wr_bank;
	logic [IDX_W-1:0]         wr_addr;
	point_t                   wr_data;
	logic signed [DIF_W-1:0]  dif;
	logic signed [SQ_W-1:0]   prod;
	logic [TW-1:0]            thr_fx;
	logic                     rd_valid;
	logic                     is_near;
	point_t                   mean;
	logic signed [SUM_W-1:0]  coord_in [3];

	assign rd_addr  = cmd.sel_ref ? r_q[IDX_W-1:0] : j_q[IDX_W-1:0];
	assign rd_valid = pt_valid(rdata_q);
	assign thr_fx   = TW'(thr_q) << FRAC_BITS;

	always_comb begin
		case (cmd.sq_coord)
			COORD_Y: dif = DIF_W'(rdata_q.y) - DIF_W'(ref_q.y);
			COORD_Z: dif = DIF_W'(rdata_q.z) - DIF_W'(ref_q.z);
			default: dif = DIF_W'(rdata_q.x) - DIF_W'(ref_q.x);
		endcase
	end
	assign prod = dif * dif;

	assign is_near = (j_q != r_q) && rd_valid &&
		(CMP_W'(acc_q + D2_W'(sq_q)) < CMP_W'(thr_sq_q));

	assign coord_in[0] = SUM_W'(rdata_q.x);
	assign coord_in[1] = SUM_W'(rdata_q.y);
	assign coord_in[2] = SUM_W'(rdata_q.z);

	assign mean.x = neg_q[0] ? -COORD_W'(quo_q[0]) : COORD_W'(quo_q[0]);
	assign mean.y = neg_q[1] ? -COORD_W'(quo_q[1]) : COORD_W'(quo_q[1]);
	assign mean.z = neg_q[2] ? -COORD_W'(quo_q[2]) : COORD_W'(quo_q[2]);

	always_comb begin
		wr_en   = 1'b0;
		wr_bank = bank_q;
		wr_addr = cnt_q[IDX_W-1:0];
		wr_data = '{x: in_x, y: in_y, z: in_z};
		if (cmd.load_wr && (cnt_q < CNT_W'(MAX_POINTS))) begin
			wr_en = 1'b1;
		end else if (cmd.acc_pt && !mask_q[j_q[IDX_W-1:0]] && rd_valid) begin
			wr_en   = 1'b1;
			wr_bank = ~bank_q;
			wr_addr = k_q[IDX_W-1:0];
			wr_data = rdata_q;
		end else if (cmd.div_wr) begin
			wr_en   = 1'b1;
			wr_bank = ~bank_q;
			wr_addr = '0;
			wr_data = mean;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && !wr_bank) mem0[wr_addr] <= wr_data;
		if (wr_en && wr_bank) mem1[wr_addr] <= wr_data;
		rdata_q <= bank_q ? mem1[rd_addr] : mem0[rd_addr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.thr_sq) thr_sq_q <= thr_fx * thr_fx;
		if (cmd.ref_ld) ref_q <= rdata_q;
		if (cmd.sq_en) sq_q <= SQ_W'(prod);
		if (cmd.acc_ld) acc_q <= D2_W'(sq_q);
		else if (cmd.acc_add) acc_q <= acc_q + D2_W'(sq_q);
		if (cmd.out_ld) begin
			out_x    <= rdata_q.x;
			out_y    <= rdata_q.y;
			out_z    <= rdata_q.z;
			out_last <= (j_q == cnt_q - CNT_W'(1));
		end
		for (int c = 0; c < 3; c++) begin
			if (cmd.merge_init) begin
				sum_q[c] <= '0;
			end else if (cmd.acc_pt && mask_q[j_q[IDX_W-1:0]]) begin
				sum_q[c] <= sum_q[c] + coord_in[c];
			end
			if (cmd.div_start) begin
				neg_q[c] <= sum_q[c][SUM_W-1];
				quo_q[c] <= sum_q[c][SUM_W-1] ? SUM_W'(-sum_q[c]) : SUM_W'(sum_q[c]);
				rem_q[c] <= '0;
			end else if (cmd.div_step) begin
				// restoring division, one quotient bit per cycle
				if ({rem_q[c][REM_W-2:0], quo_q[c][SUM_W-1]} >= REM_W'(n_q)) begin
					rem_q[c] <= {rem_q[c][REM_W-2:0], quo_q[c][SUM_W-1]} - REM_W'(n_q);
					quo_q[c] <= {quo_q[c][SUM_W-2:0], 1'b1};
				end else begin
					rem_q[c] <= {rem_q[c][REM_W-2:0], quo_q[c][SUM_W-1]};
					quo_q[c] <= {quo_q[c][SUM_W-2:0], 1'b0};
				end
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RESET;
			bank_q <= 1'b0;
			cnt_q  <= '0;
			r_q    <= '0;
			j_q    <= '0;
			k_q    <= '0;
			n_q    <= '0;
			mask_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (cfg_valid) thr_q <= cfg_data;
			if (cmd.load_wr && (cnt_q < CNT_W'(MAX_POINTS))) cnt_q <= cnt_q + CNT_W'(1);
			if (cmd.r_clr) r_q <= '0;
			else if (cmd.r_inc) r_q <= r_q + CNT_W'(1);
			if (cmd.j_clr || cmd.merge_init) j_q <= '0;
			else if (cmd.j_inc) j_q <= j_q + CNT_W'(1);
			if (cmd.mask_clr) mask_q <= '0;
			else if (cmd.near_chk && is_near) mask_q[j_q[IDX_W-1:0]] <= 1'b1;
			else if (cmd.merge_init) mask_q[r_q[IDX_W-1:0]] <= 1'b1;
			if (cmd.merge_init) begin
				k_q <= CNT_W'(1);
				n_q <= '0;
			end else if (cmd.acc_pt) begin
				if (mask_q[j_q[IDX_W-1:0]]) n_q <= n_q + CNT_W'(1);
				else if (rd_valid) k_q <= k_q + CNT_W'(1);
			end
			if (cmd.div_start) dcnt_q <= '0;
			else if (cmd.div_step) dcnt_q <= dcnt_q + DCNT_W'(1);
			if (cmd.div_wr) begin
				cnt_q  <= k_q;
				bank_q <= ~bank_q;
			end
			if (cmd.cnt_clr) begin
				cnt_q  <= '0;
				k_q    <= '0;
				n_q    <= '0;
				mask_q <= '0;
			end
		end
	end

	assign stat.r_end     = (r_q == cnt_q);
	assign stat.j_end     = (j_q == cnt_q);
	assign stat.j_last    = (j_q == cnt_q - CNT_W'(1));
	assign stat.rd_valid  = rd_valid;
	assign stat.mask_zero = (mask_q == '0);
	assign stat.div_done  = (dcnt_q == DCNT_W'(SUM_W));

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_POINTS))
		else $error("point count above capacity");
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= cnt_q)
		else $error("compacted count exceeds point count");
	a_n_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CNT_W'(MAX_POINTS))
		else $error("cluster member count above capacity");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (n_q >= CNT_W'(2)))
		else $error("divide with fewer than two members");

endmodule

/* rtl/core/threshold_point_merge_clustering_core.sv */
// Top level of the threshold point-merge clustering core.
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | in_x, in_y, in_z, in_last
//  out     | out_valid / out_ready| out_x, out_y, out_z, out_last
//  cfg     | cfg_valid / cfg_ready| cfg_data (distance_threshold)
// Loading accepts one item per cycle; the merge loop runs after the last item.
// Each reference scan squares the x, y and z differences of every point in turn (one shared multiplier, one read port);
// each merge reads every point again to sum or compact it, then runs the divider and writes the mean back.
// Emission waits on out_ready for each result; no items are taken meanwhile.
// Reset is asynchronous, active low; the threshold resets to 300.
module threshold_point_merge_clustering_core #(
	parameter int MAX_POINTS = tpmc_pkg::MAX_POINTS_DEF,
	parameter int FRAC_BITS  = tpmc_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [tpmc_pkg::COORD_W-1:0] in_x,
	input  logic signed [tpmc_pkg::COORD_W-1:0] in_y,
	input  logic signed [tpmc_pkg::COORD_W-1:0] in_z,
	input  logic                                in_last,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [tpmc_pkg::COORD_W-1:0] out_x,
	output logic signed [tpmc_pkg::COORD_W-1:0] out_y,
	output logic signed [tpmc_pkg::COORD_W-1:0] out_z,
	output logic                                out_last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tpmc_pkg::THR_W-1:0]          cfg_data
);
	import tpmc_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	tpmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_last   (in_last),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tpmc_dp #(
		.MAX_POINTS (MAX_POINTS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_x      (in_x),
		.in_y      (in_y),
		.in_z      (in_z),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.out_last  (out_last)
	);

endmodule

/* test/tb_threshold_point_merge_clustering_core.sv */
// Testbench for the threshold point-merge clustering core: directed sets, then random clustered sets.
module tb_threshold_point_merge_clustering_core;
	timeunit 1ns;
	timeprecision 1ps;

	import tpmc_pkg::*;

	localparam int NPTS = MAX_POINTS_DEF;
	localparam int FB   = FRAC_BITS_DEF;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic               last;
		logic               typed;
		logic [COORD_W-1:0] ex;
		logic [COORD_W-1:0] ey;
		logic [COORD_W-1:0] ez;
	} dir_row_t;

	typedef struct {
		point_t p;
		logic   last;
	} cluster_out_t;

	localparam int DIR_N = 18;
	localparam dir_row_t DIR_ROWS[DIR_N] = '{
		'{24'h7fffff, 24'h7fffff, 24'h7fffff, 1'b1, 1'b1, 24'h7fffff, 24'h7fffff, 24'h7fffff},
		'{24'h800000, 24'h800000, 24'h800000, 1'b1, 1'b1, 24'h800000, 24'h800000, 24'h800000},
		'{24'h000000, 24'h000000, 24'h000000, 1'b1, 1'b1, 24'h000000, 24'h000000, 24'h000000},
		'{24'h000001, 24'hffffff, 24'h000001, 1'b1, 1'b1, 24'h000001, 24'hffffff, 24'h000001},
		// plain merge of two near points
		'{24'h000100, 24'h000100, 24'h000100, 1'b0, 1'b0, 24'h0, 24'h0, 24'h0},
		'{24'h000200, 24'h000200, 24'h000300, 1'b1, 1'b0, 24'h0, 24'h0, 24'h0},
		// negative mean truncates toward zero
		'{24'hfffffd, 24'h000005, 24'h000007, 1'b0, 1'b0, 24'h0, 24'h0, 24'h0},
		'{24'hfffffc, 24'h000006, 24'h000008, 1'b1, 1'b0, 24'h0, 24'h0, 24'h0},
		// mean lands on zero x, far point kept behind it
		'{24'hfffff6, 24'h000005, 24'h000005, 1'b0, 1'b0, 24'h0, 24'h0, 24'h0},
		'{24'h00000a, 24'h000005, 24'h000006, 1'b0, 1'b0, 24'h0, 24'h0, 24'h0},
		'{24'h100000, 24'h100000, 24'h100000, 1'b1, 1'b0, 24'h0, 24'h0, 24'h0},
		// invalid point dropped once a merge happens
		'{24'h000005, 24'h000000, 24'h000005, 1'b0, 1'b0, 24'h0, 24'h0, 24'h0},
		'{24'h000006, 24'h000006, 24'h000006, 1'b0, 1'b0, 24'h0, 24'h0, 24'h0},
		'{24'h000007, 24'h000007, 24'h000007, 1'b1, 1'b0, 24'h0, 24'h0, 24'h0},
		// distance exactly at threshold (300 units): no merge
		'{24'h000100, 24'h000100, 24'h000100, 1'b0, 1'b0, 24'h0, 24'h0, 24'h0},
		'{24'h012d00, 24'h000100, 24'h000100, 1'b1, 1'b0, 24'h0, 24'h0, 24'h0},
		// one raw step below threshold: merge
		'{24'h000100, 24'h000100, 24'h000100, 1'b0, 1'b0, 24'h0, 24'h0, 24'h0},
		'{24'h012cff, 24'h000100, 24'h000100, 1'b1, 1'b0, 24'h0, 24'h0, 24'h0}
	};

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic signed [COORD_W-1:0]  in_x = '0;
	logic signed [COORD_W-1:0]  in_y = '0;
	logic signed [COORD_W-1:0]  in_z = '0;
	logic                       in_last = 1'b0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [COORD_W-1:0]  out_x;
	logic signed [COORD_W-1:0]  out_y;
	logic signed [COORD_W-1:0]  out_z;
	logic                       out_last;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [THR_W-1:0]           cfg_data = '0;

	threshold_point_merge_clustering_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_x      (in_x),
		.in_y      (in_y),
		.in_z      (in_z),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.out_last  (out_last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model state
	logic signed [COORD_W-1:0] set_x[NPTS];
	logic signed [COORD_W-1:0] set_y[NPTS];
	logic signed [COORD_W-1:0] set_z[NPTS];
	int                        set_count = 0;
	logic [THR_W-1:0]          merge_thr = THR_RESET;

	cluster_out_t pending_points[$];
	int           mismatches = 0;
	int           burst_left = 0;
	int           items_sent = 0;

	function automatic bit slot_valid(int i);
		return set_x[i] != 0 && set_y[i] != 0 && set_z[i] != 0;
	endfunction

	function automatic bit slots_near(int a, int b);
		longint dx, dy, dz, t;
		dx = longint'(set_x[a]) - longint'(set_x[b]);
		dy = longint'(set_y[a]) - longint'(set_y[b]);
		dz = longint'(set_z[a]) - longint'(set_z[b]);
		t  = longint'(merge_thr) << FB;
		return dx * dx + dy * dy + dz * dz < t * t;
	endfunction

	task automatic merge_set();
		int r, j, k, n;
		logic [NPTS-1:0] near;
		longint sx, sy, sz;
		logic signed [COORD_W-1:0] nx[NPTS], ny[NPTS], nz[NPTS];
		r = 0;
		while (r < set_count) begin
			near = '0;
			if (slot_valid(r))
				for (j = 0; j < set_count; j++)
					if (j != r && slot_valid(j) && slots_near(r, j))
						near[j] = 1'b1;
			if (near == '0) begin
				r++;
			end else begin
				near[r] = 1'b1;
				sx = 0; sy = 0; sz = 0; n = 0; k = 1;
				for (j = 0; j < set_count; j++) begin
					if (near[j]) begin
						sx += set_x[j];
						sy += set_y[j];
						sz += set_z[j];
						n++;
					end else if (slot_valid(j)) begin
						nx[k] = set_x[j];
						ny[k] = set_y[j];
						nz[k] = set_z[j];
						k++;
					end
				end
				nx[0] = COORD_W'(sx / n);
				ny[0] = COORD_W'(sy / n);
				nz[0] = COORD_W'(sz / n);
				for (j = 0; j < k; j++) begin
					set_x[j] = nx[j];
					set_y[j] = ny[j];
					set_z[j] = nz[j];
				end
				set_count = k;
				r = 0;
			end
		end
	endtask

	task automatic absorb_point(logic [COORD_W-1:0] x, y, z, logic last);
		cluster_out_t e;
		if (set_count < NPTS) begin
			set_x[set_count] = x;
			set_y[set_count] = y;
			set_z[set_count] = z;
			set_count++;
		end
		if (last) begin
			merge_set();
			for (int i = 0; i < set_count; i++) begin
				e.p.x  = set_x[i];
				e.p.y  = set_y[i];
				e.p.z  = set_z[i];
				e.last = (i + 1 == set_count);
				pending_points = {pending_points, e};
			end
			set_count = 0;
		end
	endtask

	task automatic send_point(logic [COORD_W-1:0] x, y, z, logic last);
		if (burst_left == 0) begin
			if (in_valid) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		in_x     <= x;
		in_y     <= y;
		in_z     <= z;
		in_last  <= last;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		absorb_point(x, y, z, last);
		burst_left--;
		items_sent++;
	endtask

	task automatic drain_and_settle();
		if (in_valid) in_valid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_threshold(logic [THR_W-1:0] v);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		merge_thr = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_set();
		int size, ncent, c, spread;
		int cx[3], cy[3], cz[3];
		bit noise;
		logic [COORD_W-1:0] x, y, z;
		size  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 18) : $urandom_range(1, 8);
		noise = ($urandom_range(0, 6) == 0);
		ncent = $urandom_range(1, 3);
		spread = int'(merge_thr) * 256;
		if (spread > (1 << 21)) spread = 1 << 21;
		for (int i = 0; i < 3; i++) begin
			cx[i] = int'($urandom_range(0, 8000000)) - 4000000;
			cy[i] = int'($urandom_range(0, 8000000)) - 4000000;
			cz[i] = int'($urandom_range(0, 8000000)) - 4000000;
		end
		for (int i = 0; i < size; i++) begin
			if (noise) begin
				x = COORD_W'($urandom);
				y = COORD_W'($urandom);
				z = COORD_W'($urandom);
				// a stray last bit splits the set early
				send_point(x, y, z, (i == size - 1) || ($urandom_range(0, 7) == 0));
			end else begin
				c = $urandom_range(0, ncent - 1);
				x = COORD_W'(cx[c] + int'($urandom_range(0, 2 * spread)) - spread);
				y = COORD_W'(cy[c] + int'($urandom_range(0, 2 * spread)) - spread);
				z = COORD_W'(cz[c] + int'($urandom_range(0, 2 * spread)) - spread);
				if ($urandom_range(0, 11) == 0) begin
					case ($urandom_range(0, 2))
						0: x = '0;
						1: y = '0;
						default: z = '0;
					endcase
				end
				send_point(x, y, z, i == size - 1);
			end
		end
	endtask

	// receiver: out_ready follows one of four randomly redrawn patterns
	int unsigned rx_cycle = 0;
	int unsigned rx_mode  = 0;
	always @(posedge clk) begin
		cluster_out_t e;
		rx_cycle++;
		if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= (rx_cycle % 4 == 0);
			default: out_ready <= ($urandom_range(0, 9) != 0);
		endcase
		if (arst_n && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item x=%h y=%h z=%h last=%b",
						out_x, out_y, out_z, out_last);
			end else begin
				e = pending_points.pop_front();
				if (out_x !== e.p.x || out_y !== e.p.y || out_z !== e.p.z
						|| out_last !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %h %h %h %b got %h %h %h %b",
							e.p.x, e.p.y, e.p.z, e.last, out_x, out_y, out_z, out_last);
				end
			end
		end
	end

	initial begin
		cluster_out_t e;
		logic [THR_W-1:0] phase_thr[4];
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			send_point(DIR_ROWS[i].x, DIR_ROWS[i].y, DIR_ROWS[i].z, DIR_ROWS[i].last);
			if (DIR_ROWS[i].typed) begin
				void'(pending_points.pop_back());
				e.p.x = DIR_ROWS[i].ex;
				e.p.y = DIR_ROWS[i].ey;
				e.p.z = DIR_ROWS[i].ez;
				e.last = 1'b1;
				pending_points = {pending_points, e};
			end
		end
		drain_and_settle();

		phase_thr[0] = 16'd1;
		phase_thr[1] = 16'hffff;
		phase_thr[2] = THR_W'($urandom_range(2, 65534));
		phase_thr[3] = THR_W'($urandom_range(50, 2000));
		for (int ph = 0; ph < 4; ph++) begin
			write_threshold(phase_thr[ph]);
			items_sent = 0;
			while (items_sent < 35) begin
				send_random_set();
				if ($urandom_range(0, 9) == 0) drain_and_settle();
			end
			drain_and_settle();
		end

		if (mismatches == 0)
			$display("tb_threshold_point_merge_clustering_core: clean");
		else
			$display("tb_threshold_point_merge_clustering_core: errors");
		$finish;
	end

	initial begin
		#200ms;
		$display("tb_threshold_point_merge_clustering_core: errors");
		$finish;
	end

endmodule
